FILE: rtl/core/wmf_pkg.sv
// Shared constants, types and helper functions of the windowed median filter.
`default_nettype none

package wmf_pkg;

    localparam int MAX_WINDOW = 5;
    localparam int MAX_LINE   = 1024;
    localparam int MAX_LINES  = 4096;

    localparam int PIX_W      = 8;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 13;
    localparam int WIN_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LINES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TAPS  = CFG_IDX_W'(3);

    localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(256);
    localparam logic [CNT_W-1:0] CNT_RESET   = CNT_W'(256);
    localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(3);

    localparam int CELLS      = MAX_WINDOW * MAX_WINDOW;
    localparam int RANK_W     = $clog2(CELLS);
    localparam int HALF_W     = $clog2((MAX_WINDOW - 1) / 2 + 1);
    localparam int COL_W      = $clog2(MAX_LINE);
    localparam int OROW_W     = $clog2(MAX_LINES);
    localparam int LINE_W     = OROW_W + 2;
    localparam int POS_W      = $clog2(MAX_LINE * MAX_LINES) + 1;
    localparam int WORD_W     = (MAX_WINDOW - 1) * PIX_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = FIFO_AW + 1;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [HALF_W-1:0] t_half;
    typedef logic [RANK_W-1:0] t_rank;

    // Half extent of the effective odd window for a raw size register.
    function automatic t_half eff_half(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] m;
        m = (int'(v) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : v;
        if (v == '0) begin
            return '0;
        end
        return HALF_W'((m - WIN_W'(1)) >> 1);
    endfunction

    // Sorted position of the median when the unused cells are filled with zero.
    function automatic t_rank median_rank(input t_half hl, input t_half ht);
        int n;
        n = (2 * int'(hl) + 1) * (2 * int'(ht) + 1);
        return RANK_W'(CELLS - 1 - ((n - 1) >> 1));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wmf_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
`default_nettype none

interface wmf_pix_if;
    logic              valid;
    logic              ready;
    wmf_pkg::t_pix     pixel;
    logic              flush;
    modport source (output valid, output pixel, output flush, input ready);
    modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface wmf_res_if;
    logic              valid;
    logic              ready;
    wmf_pkg::t_pix     median_value;
    logic              frame_end;
    modport source (output valid, output median_value, output frame_end, input ready);
    modport sink   (input valid, input median_value, input frame_end, output ready);
endinterface

interface wmf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [wmf_pkg::CFG_IDX_W-1:0]       index;
    logic [wmf_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/windowed_median_image_filter_core.sv
// Streaming 2D median filter top level: line memory, window, rank network and output queue.
// The item that completes a window passes stages A to E before its result leaves the rank
// network; that item trails the center pixel by half_lines * line_length + half_taps items.
// Throughput: one item per cycle while queue credit lasts, set by the single-port-per-side
// line memory and fully pipelined rank network; an eight-entry output queue absorbs stalls.
// Reset: synchronous active-low; restores register defaults and clears counters and valids.
// The line memory needs no clearing, since rows outside the current frame are masked.
`default_nettype none

module windowed_median_image_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wmf_pix_if.sink     i_pix,
    wmf_res_if.source   o_res,
    wmf_cfg_if.sink     i_cfg
);

    localparam int W       = wmf_pkg::MAX_WINDOW;
    localparam int CELLS   = wmf_pkg::CELLS;
    localparam int PIX_W   = wmf_pkg::PIX_W;
    localparam int LEN_W   = wmf_pkg::LEN_W;
    localparam int CNT_W   = wmf_pkg::CNT_W;
    localparam int COL_W   = wmf_pkg::COL_W;
    localparam int OROW_W  = wmf_pkg::OROW_W;
    localparam int LINE_W  = wmf_pkg::LINE_W;
    localparam int POS_W   = wmf_pkg::POS_W;
    localparam int WORD_W  = wmf_pkg::WORD_W;
    localparam int RANK_W  = wmf_pkg::RANK_W;
    localparam int HALF_W  = wmf_pkg::HALF_W;
    localparam int FDEPTH  = wmf_pkg::FIFO_DEPTH;
    localparam int FAW     = wmf_pkg::FIFO_AW;
    localparam int CRW     = wmf_pkg::CREDIT_W;

    // Configuration registers.
    logic [LEN_W-1:0]          r_len;
    logic [CNT_W-1:0]          r_cnt;
    logic [wmf_pkg::WIN_W-1:0] r_wl;
    logic [wmf_pkg::WIN_W-1:0] r_wt;
    logic                      cfg_restart;

    assign i_cfg.ready = 1'b1;
    assign cfg_restart = i_cfg.valid && (i_cfg.index <= wmf_pkg::REG_WINDOW_TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= wmf_pkg::LEN_RESET;
            r_cnt <= wmf_pkg::CNT_RESET;
            r_wl  <= wmf_pkg::WIN_RESET;
            r_wt  <= wmf_pkg::WIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wmf_pkg::REG_LINE_LENGTH:  r_len <= i_cfg.data[LEN_W-1:0];
                wmf_pkg::REG_LINE_COUNT:   r_cnt <= i_cfg.data[CNT_W-1:0];
                wmf_pkg::REG_WINDOW_LINES: r_wl  <= i_cfg.data[wmf_pkg::WIN_W-1:0];
                wmf_pkg::REG_WINDOW_TAPS:  r_wt  <= i_cfg.data[wmf_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry.
    logic [LEN_W-1:0]        len_e;
    logic [CNT_W-1:0]        cnt_e;
    wmf_pkg::t_half          hl;
    wmf_pkg::t_half          ht;
    wmf_pkg::t_rank          med_rank;
    logic [HALF_W+LEN_W-1:0] dly_rows;
    logic [POS_W-1:0]        dly;

    always_comb begin
        if (r_len == '0) begin
            len_e = LEN_W'(1);
        end else if (int'(r_len) > wmf_pkg::MAX_LINE) begin
            len_e = LEN_W'(wmf_pkg::MAX_LINE);
        end else begin
            len_e = r_len;
        end
        if (r_cnt == '0) begin
            cnt_e = CNT_W'(1);
        end else if (int'(r_cnt) > wmf_pkg::MAX_LINES) begin
            cnt_e = CNT_W'(wmf_pkg::MAX_LINES);
        end else begin
            cnt_e = r_cnt;
        end
    end

    assign hl       = wmf_pkg::eff_half(r_wl);
    assign ht       = wmf_pkg::eff_half(r_wt);
    assign med_rank = wmf_pkg::median_rank(hl, ht);
    assign dly_rows = (HALF_W+LEN_W)'(hl) * (HALF_W+LEN_W)'(len_e);
    assign dly      = POS_W'(dly_rows) + POS_W'(ht);

    // Input position and output position counters.
    logic [COL_W-1:0]  r_col, n_col;
    logic [LINE_W-1:0] r_line, n_line;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [OROW_W-1:0] r_orow, n_orow;
    logic [COL_W-1:0]  r_ocol, n_ocol;
    logic [CRW-1:0]    r_credit, n_credit;
    logic              pix_acc;
    logic              res_acc;
    logic              in_frame;
    logic              out_en;
    logic              last;
    wmf_pkg::t_pix     pix_in;

    assign i_pix.ready = (r_credit < CRW'(FDEPTH));
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign in_frame    = (r_line < LINE_W'(cnt_e));
    assign out_en      = (r_pos >= dly);
    assign last        = out_en && (r_orow == OROW_W'(cnt_e - CNT_W'(1)))
                         && (r_ocol == COL_W'(len_e - LEN_W'(1)));
    assign pix_in      = (i_pix.flush || !in_frame) ? '0 : i_pix.pixel;

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        n_pos  = r_pos;
        n_orow = r_orow;
        n_ocol = r_ocol;
        if (cfg_restart || (pix_acc && last)) begin
            n_col  = '0;
            n_line = '0;
            n_pos  = '0;
            n_orow = '0;
            n_ocol = '0;
        end else if (pix_acc) begin
            n_pos = r_pos + POS_W'(1);
            if (LEN_W'(r_col) + LEN_W'(1) == len_e) begin
                n_col  = '0;
                n_line = r_line + LINE_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (out_en) begin
                if (LEN_W'(r_ocol) + LEN_W'(1) == len_e) begin
                    n_ocol = '0;
                    n_orow = r_orow + OROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    assign n_credit = r_credit + CRW'(pix_acc && out_en) - CRW'(res_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_line   <= '0;
            r_pos    <= '0;
            r_orow   <= '0;
            r_ocol   <= '0;
            r_credit <= '0;
        end else begin
            r_col    <= n_col;
            r_line   <= n_line;
            r_pos    <= n_pos;
            r_orow   <= n_orow;
            r_ocol   <= n_ocol;
            r_credit <= n_credit;
        end
    end

    // Stage A: line memory read data; write back the shifted column.
    logic              r_a_valid;
    logic              r_a_emit;
    logic              r_a_last;
    wmf_pkg::t_pix     r_a_pix;
    logic [COL_W-1:0]  r_a_col;
    logic [OROW_W-1:0] r_a_orow;
    logic [COL_W-1:0]  r_a_ocol;
    logic [WORD_W-1:0] r_mem [wmf_pkg::MAX_LINE];
    logic [WORD_W-1:0] r_rd;
    logic              r_byp;
    logic [WORD_W-1:0] r_bypw;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] wdata;

    assign word_a = r_byp ? r_bypw : r_rd;
    assign wdata  = {word_a[WORD_W-PIX_W-1:0], r_a_pix};

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_mem[r_a_col] <= wdata;
        end
        if (pix_acc) begin
            r_rd <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_emit  <= 1'b0;
        end else begin
            r_a_valid <= pix_acc;
            r_a_emit  <= pix_acc && out_en;
        end
        if (pix_acc) begin
            r_a_last <= last;
            r_a_pix  <= pix_in;
            r_a_col  <= r_col;
            r_a_orow <= r_orow;
            r_a_ocol <= r_ocol;
            r_byp    <= r_a_valid && (r_a_col == r_col);
            r_bypw   <= wdata;
        end
    end

    // Stage B: window of the last W columns, newest in column zero.
    wmf_pkg::t_pix     r_win [W][W];
    logic              r_b_emit;
    logic              r_b_last;
    logic [OROW_W-1:0] r_b_orow;
    logic [COL_W-1:0]  r_b_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_emit <= 1'b0;
        end else begin
            r_b_emit <= r_a_valid && r_a_emit;
        end
        if (r_a_valid) begin
            for (int k = 1; k < W; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0][0] <= r_a_pix;
            for (int j = 1; j < W; j++) begin
                r_win[0][j] <= word_a[(j-1)*PIX_W +: PIX_W];
            end
            r_b_last <= r_a_last;
            r_b_orow <= r_a_orow;
            r_b_ocol <= r_a_ocol;
        end
    end

    // Stage C: mask cells outside the image or the window.
    logic [COL_W+1:0]  colv [W];
    logic [OROW_W+1:0] rowv [W];
    logic [W-1:0]      colok;
    logic [W-1:0]      rowok;
    wmf_pkg::t_pix     mv [CELLS];
    wmf_pkg::t_pix     r_c_val [CELLS];
    logic              r_c_emit;
    logic              r_c_last;

    always_comb begin
        for (int k = 0; k < W; k++) begin
            colv[k]  = (COL_W+2)'(r_b_ocol) + (COL_W+2)'(ht) - (COL_W+2)'(k);
            colok[k] = !colv[k][COL_W+1] && (colv[k][COL_W:0] < (COL_W+1)'(len_e))
                       && (k <= 2 * int'(ht));
        end
        for (int j = 0; j < W; j++) begin
            rowv[j]  = (OROW_W+2)'(r_b_orow) + (OROW_W+2)'(hl) - (OROW_W+2)'(j);
            rowok[j] = !rowv[j][OROW_W+1] && (rowv[j][OROW_W:0] < (OROW_W+1)'(cnt_e))
                       && (j <= 2 * int'(hl));
        end
        for (int j = 0; j < W; j++) begin
            for (int k = 0; k < W; k++) begin
                mv[j*W+k] = (rowok[j] && colok[k]) ? r_win[k][j] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_emit <= 1'b0;
        end else begin
            r_c_emit <= r_b_emit;
        end
        r_c_val  <= mv;
        r_c_last <= r_b_last;
    end

    // Stage D: pairwise order matrix with index tie break.
    logic [CELLS-1:0] bf [CELLS];
    logic [CELLS-1:0] r_d_bf [CELLS];
    wmf_pkg::t_pix    r_d_val [CELLS];
    logic             r_d_emit;
    logic             r_d_last;

    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            for (int j = 0; j < CELLS; j++) begin
                bf[i][j] = (r_c_val[j] < r_c_val[i]) || ((r_c_val[j] == r_c_val[i]) && (j < i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_emit <= 1'b0;
        end else begin
            r_d_emit <= r_c_emit;
        end
        r_d_bf   <= bf;
        r_d_val  <= r_c_val;
        r_d_last <= r_c_last;
    end

    // Stage E: ranks, then select the cell whose rank is the median position.
    wmf_pkg::t_rank r_e_rank [CELLS];
    wmf_pkg::t_pix  r_e_val [CELLS];
    logic           r_e_emit;
    logic           r_e_last;
    logic [CELLS-1:0] match;
    wmf_pkg::t_pix  med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_emit <= 1'b0;
        end else begin
            r_e_emit <= r_d_emit;
        end
        for (int i = 0; i < CELLS; i++) begin
            r_e_rank[i] <= RANK_W'($countones(r_d_bf[i]));
        end
        r_e_val  <= r_d_val;
        r_e_last <= r_d_last;
    end

    always_comb begin
        med = '0;
        for (int i = 0; i < CELLS; i++) begin
            match[i] = (r_e_rank[i] == med_rank);
            med      = med | (match[i] ? r_e_val[i] : '0);
        end
    end

    // Output queue.
    wmf_pkg::t_pix  r_q_val [FDEPTH];
    logic [FDEPTH-1:0] r_q_end;
    logic [FAW-1:0] r_wp;
    logic [FAW-1:0] r_rp;
    logic [CRW-1:0] r_fcnt;

    assign o_res.valid        = (r_fcnt != '0);
    assign o_res.median_value = r_q_val[r_rp];
    assign o_res.frame_end    = r_q_end[r_rp];
    assign res_acc            = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (r_e_emit) begin
                r_wp <= r_wp + FAW'(1);
            end
            if (res_acc) begin
                r_rp <= r_rp + FAW'(1);
            end
            r_fcnt <= r_fcnt + CRW'(r_e_emit) - CRW'(res_acc);
        end
        if (r_e_emit) begin
            r_q_val[r_wp] <= med;
            r_q_end[r_wp] <= r_e_last;
        end
    end

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_credit)
        else $error("output queue holds more items than credited");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(FDEPTH))
        else $error("credit count exceeds output queue depth");

    a_single_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_emit |-> $onehot(match))
        else $error("median selection did not match exactly one cell");

endmodule

`default_nettype wire
